@@ hw/rtl/des_pkg.sv @@
package des_pkg;

	localparam int unsigned Rounds = 16;
	localparam int unsigned HalfKeyBits = 28;
	localparam int unsigned SboxInBits = 6;
	localparam int unsigned HalfBlockBits = 32;
	localparam int unsigned SubkeyBits = 48;

	typedef logic [SubkeyBits-1:0] subkey_t;
	typedef logic [Rounds-1:0][SubkeyBits-1:0] subkey_set_t;

	localparam int unsigned TAB_IP [64] = '{
		58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
		62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
		57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
		61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

	localparam int unsigned TAB_FP [64] = '{
		40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
		38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
		36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
		34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

	localparam int unsigned TAB_EXP [48] = '{
		32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
		16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};

	localparam int unsigned TAB_PERM [32] = '{
		16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
		2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};

	localparam int unsigned TAB_PC1 [56] = '{
		57,49,41,33,25,17,9,  1,58,50,42,34,26,18,
		10,2,59,51,43,35,27,  19,11,3,60,52,44,36,
		63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
		14,6,61,53,45,37,29,  21,13,5,28,20,12,4};

	localparam int unsigned TAB_PC2 [48] = '{
		14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
		41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};

	localparam int unsigned TAB_ROT [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

	localparam logic [3:0] TAB_SBOX [8][64] = '{
		'{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
		  4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
		'{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
		  0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
		'{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
		  13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
		'{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
		  10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
		'{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
		  4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
		'{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
		  9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
		'{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
		  1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
		'{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
		  7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

	// Bit positions in the tables count from 1 at the most significant bit.
	function automatic logic [63:0] perm_ip(input logic [63:0] x);
		logic [63:0] y;
		for (int i = 0; i < 64; i++) y[63-i] = x[64-TAB_IP[i]];
		return y;
	endfunction

	function automatic logic [63:0] perm_fp(input logic [63:0] x);
		logic [63:0] y;
		for (int i = 0; i < 64; i++) y[63-i] = x[64-TAB_FP[i]];
		return y;
	endfunction

	function automatic logic [47:0] expand(input logic [31:0] x);
		logic [47:0] y;
		for (int i = 0; i < 48; i++) y[47-i] = x[32-TAB_EXP[i]];
		return y;
	endfunction

	function automatic logic [31:0] perm_p(input logic [31:0] x);
		logic [31:0] y;
		for (int i = 0; i < 32; i++) y[31-i] = x[32-TAB_PERM[i]];
		return y;
	endfunction

	function automatic logic [55:0] perm_pc1(input logic [63:0] x);
		logic [55:0] y;
		for (int i = 0; i < 56; i++) y[55-i] = x[64-TAB_PC1[i]];
		return y;
	endfunction

	function automatic logic [47:0] perm_pc2(input logic [55:0] x);
		logic [47:0] y;
		for (int i = 0; i < 48; i++) y[47-i] = x[56-TAB_PC2[i]];
		return y;
	endfunction

endpackage

@@ hw/rtl/des_key_sched.sv @@
module des_key_sched import des_pkg::*; (
	input  logic [63:0]  cipher_key,
	output subkey_set_t  subkeys
);

	// All rotations are fixed per round, so the whole schedule is wiring.
	always_comb begin
		logic [55:0] k56;
		logic [HalfKeyBits-1:0] c;
		logic [HalfKeyBits-1:0] d;
		k56 = perm_pc1(cipher_key);
		c = k56[55:28];
		d = k56[27:0];
		for (int r = 0; r < Rounds; r++) begin
			if (TAB_ROT[r] == 1) begin
				c = {c[26:0], c[27]};
				d = {d[26:0], d[27]};
			end else begin
				c = {c[25:0], c[27:26]};
				d = {d[25:0], d[27:26]};
			end
			subkeys[r] = perm_pc2({c, d});
		end
	end

endmodule

@@ hw/rtl/des_round.sv @@
module des_round import des_pkg::*; (
	input  logic [31:0] l_in,
	input  logic [31:0] r_in,
	input  subkey_t     subkey,
	output logic [31:0] l_out,
	output logic [31:0] r_out
);

	logic [47:0] e;
	logic [31:0] s;

	assign e = expand(r_in) ^ subkey;

	always_comb begin
		logic [5:0] six;
		for (int b = 0; b < 8; b++) begin
			six = e[47-SboxInBits*b -: SboxInBits];
			s[31-4*b -: 4] = TAB_SBOX[b][{six[5], six[0], six[4:1]}];
		end
	end

	assign l_out = r_in;
	assign r_out = l_in ^ perm_p(s);

endmodule

@@ hw/rtl/des_block_cipher.sv @@
// Single-DES engine, one 64-bit block per item.
//
// Input channel: drive mode (0 encrypt, 1 decrypt) and data_block with
// start high. An item is accepted at any rising edge where start is high
// and busy is low. Busy is always low, so an item can be accepted in every
// clock cycle.
//
// Result channel: result_block appears with result_valid high for exactly
// one cycle, once the item has passed the input register and the result
// register, and is taken at the rising edge that ends that cycle. Items
// leave in the order they entered. The receiver cannot stall the block
// and must take each result in the cycle it is shown.
//
// Timing: the item is captured in an input register; the initial
// permutation, all sixteen Feistel rounds and the final permutation are
// evaluated in one pass of logic into the result register. Throughput
// is one item per cycle.
//
// Configuration: cipher_key is a 64-bit register that answers at every
// APB byte address with paddr[3] low (0 to 7). Write it only while no item
// is in flight. Reset clears the key and drops any item in flight.
module des_block_cipher import des_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        mode,
	input  logic [63:0] data_block,
	output logic        result_valid,
	output logic [63:0] result_block,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	logic        cfg_wr;
	logic [63:0] key_q;
	logic        valid_s1;
	logic        mode_s1;
	logic [63:0] data_s1;
	subkey_set_t subkeys;
	logic [63:0] blk_ip;
	logic [31:0] l_chain [Rounds+1];
	logic [31:0] r_chain [Rounds+1];

	assign pready = 1'b1;
	assign busy   = 1'b0;

	// Only addresses with paddr[3] low (0 to 7) hold the key; writes elsewhere are ignored.
	assign cfg_wr = psel && penable && pwrite && pready && !paddr[3];
	assign prdata = paddr[3] ? 64'd0 : key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_wr) begin
			key_q <= pwdata;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			mode_s1 <= mode;
			data_s1 <= data_block;
		end
	end

	des_key_sched u_sched (
		.cipher_key (key_q),
		.subkeys    (subkeys)
	);

	assign blk_ip     = perm_ip(data_s1);
	assign l_chain[0] = blk_ip[63:32];
	assign r_chain[0] = blk_ip[31:0];

	// Decryption walks the same subkeys from the last one back.
	for (genvar i = 0; i < Rounds; i++) begin : g_round
		des_round u_round (
			.l_in   (l_chain[i]),
			.r_in   (r_chain[i]),
			.subkey (mode_s1 ? subkeys[Rounds-1-i] : subkeys[i]),
			.l_out  (l_chain[i+1]),
			.r_out  (r_chain[i+1])
		);
	end

	// Result register; the halves swap before the final permutation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_block <= perm_fp({r_chain[Rounds], l_chain[Rounds]});
		end
	end

`ifndef SYNTHESIS
	a_result_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start, 2))
		else $error("result without an accepted item");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 result_valid)
		else $error("accepted item produced no result");

	a_key_only_by_write: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(cfg_wr) |-> $stable(key_q))
		else $error("key changed without a write");
`endif

endmodule
